[design/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg: shared constants, types and functions of the SHA-256 hasher
// Holds the round constants, the initial hash values, the sigma functions and
// the command structs that the sequencer sends to the datapath modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE      = 8'h80;
	localparam logic [5:0] LAST_FILL     = 6'd63;
	localparam logic [5:0] SPILL_FILL    = 6'd56;
	localparam logic [5:0] LAST_ROUND    = 6'd63;
	localparam logic [2:0] LAST_WORD_IDX = 3'd7;
	localparam logic [3:0] LEN_HI_WORD   = 4'd14;
	localparam logic [3:0] LEN_LO_WORD   = 4'd15;

	// Commands to the message schedule window.
	typedef struct packed {
		logic       step;
		logic       wr_byte;
		logic       clr_tail;
		logic       zero_all;
		logic       wr_len;
		logic [5:0] fill;
		logic [7:0] data;
	} sched_cmd_t;

	// Commands to the round and chaining datapath.
	typedef struct packed {
		logic       init;
		logic       load;
		logic       step;
		logic       update;
		logic [5:0] rnd;
		logic [2:0] sel;
	} core_cmd_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

`default_nettype wire

[design/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher: SHA-256 over a byte stream
// Takes one optional message byte per transfer, compresses each full 64-byte
// block, pads on the end mark and returns the eight digest words.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+-------------------------------------
//   message  | msg_valid / msg_ready      | msg_byte, has_byte, is_last
//   digest   | digest_valid / digest_ready| digest_word, word_index, last_word
//
// A byte that does not complete a block leaves the hasher idle, and msg_ready
// stays high. A byte that completes a block is followed by 64 rounds on the
// single shared round unit and an update that adds the result into the
// chaining words. An end mark adds a padding step and a compression, plus the
// compression of a length-only block when the tail holds 56 or more bytes,
// and then eight digest transfers at one per cycle while digest_ready is high.
// After reset the chaining words hold the initial hash values and the byte
// and bit counts are zero; there is no clearing pass. A stalled digest holds
// the block in the digest phase and msg_ready stays low until the last word
// is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_ready,
	input  logic [7:0]  msg_byte,
	input  logic        has_byte,
	input  logic        is_last,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha_pkg::*;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_ROUND = 6'b000100,
		ST_UPD   = 6'b001000,
		ST_LEN   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t      state_q;
	state_t      state_d;
	logic [5:0]  fill_q;
	logic [63:0] bit_count_q;
	logic [5:0]  rnd_q;
	logic [2:0]  out_idx_q;
	logic        pad_pend_q;   // end mark arrived with the byte that filled a block
	logic        spill_q;      // padding spilled; a length-only block follows
	logic        final_q;      // the block in flight is the last of the message

	logic        msg_xfer;
	logic        digest_xfer;
	logic        block_full;
	logic        spill;
	sched_cmd_t  sched_cmd;
	core_cmd_t   core_cmd;
	logic [31:0] sched_wt;

	assign msg_ready    = (state_q == ST_IDLE);
	assign digest_valid = (state_q == ST_OUT);
	assign msg_xfer     = msg_valid && msg_ready;
	assign digest_xfer  = digest_valid && digest_ready;
	assign block_full   = has_byte && (fill_q == LAST_FILL);
	assign spill        = (fill_q >= SPILL_FILL);

	assign word_index   = out_idx_q;
	assign last_word    = (out_idx_q == LAST_WORD_IDX);

	// Next state and the commands to the schedule window and round unit.
	always_comb begin
		state_d   = state_q;
		sched_cmd = '0;
		core_cmd  = '0;
		sched_cmd.fill = fill_q;
		sched_cmd.data = msg_byte;
		core_cmd.rnd   = rnd_q;
		core_cmd.sel   = out_idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_xfer) begin
					sched_cmd.wr_byte = has_byte;
					if (block_full) begin
						core_cmd.load = 1'b1;
						state_d = ST_ROUND;
					end else if (is_last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				// The end marker byte, a cleared tail and, when it fits, the length.
				sched_cmd.wr_byte  = 1'b1;
				sched_cmd.data     = PAD_BYTE;
				sched_cmd.clr_tail = 1'b1;
				sched_cmd.wr_len   = !spill;
				core_cmd.load      = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				sched_cmd.step = 1'b1;
				core_cmd.step  = 1'b1;
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				core_cmd.update = 1'b1;
				priority if (final_q) begin
					state_d = ST_OUT;
				end else if (spill_q) begin
					state_d = ST_LEN;
				end else if (pad_pend_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_LEN: begin
				sched_cmd.zero_all = 1'b1;
				sched_cmd.wr_len   = 1'b1;
				core_cmd.load      = 1'b1;
				state_d = ST_ROUND;
			end
			ST_OUT: begin
				if (digest_xfer && last_word) begin
					core_cmd.init = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			bit_count_q <= '0;
			rnd_q       <= '0;
			out_idx_q   <= '0;
			pad_pend_q  <= 1'b0;
			spill_q     <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (msg_xfer) begin
				if (has_byte) begin
					fill_q      <= fill_q + 6'd1;
					bit_count_q <= bit_count_q + 64'd8;
				end
				pad_pend_q <= block_full && is_last;
			end
			if (state_q == ST_PAD) begin
				spill_q <= spill;
				final_q <= !spill;
			end
			if (state_q == ST_LEN) begin
				spill_q <= 1'b0;
				final_q <= 1'b1;
			end
			if ((state_q == ST_UPD) && !final_q && !spill_q) begin
				pad_pend_q <= 1'b0;
			end
			if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (digest_xfer) begin
				out_idx_q <= out_idx_q + 3'd1;
				if (last_word) begin
					fill_q      <= '0;
					bit_count_q <= '0;
					final_q     <= 1'b0;
				end
			end
		end
	end

	sha_sched u_sched (
		.clk (clk),
		.cmd (sched_cmd),
		.len (bit_count_q),
		.wt  (sched_wt)
	);

	sha_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (core_cmd),
		.wt     (sched_wt),
		.word   (digest_word)
	);

`ifndef NO_ASSERTIONS
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_ready && digest_valid))
		else $error("message and digest sides active together");

	a_block_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_xfer && block_full) |=> (state_q == ST_ROUND))
		else $error("full block did not start compression");

	a_round_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rnd_q != 6'd0) |-> (state_q == ST_ROUND))
		else $error("round counter left nonzero outside compression");

	a_digest_done: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_xfer && last_word) |=> (msg_ready && (fill_q == 6'd0)
			&& (bit_count_q == 64'd0)))
		else $error("hasher not restarted after the final digest word");
`endif

endmodule

`default_nettype wire

[design/sha_sched.sv]
// ----------------------------------------------------------------------------
// sha_sched: message block and rolling schedule window
// Sixteen words that collect message bytes and padding, then shift once per
// round while the expanded schedule word enters at the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_sched (
	input  logic                clk,
	input  sha_pkg::sched_cmd_t cmd,
	input  logic [63:0]         len,
	output logic [31:0]         wt
);
	import sha_pkg::*;

	logic [31:0] win_q    [16];
	logic [31:0] shift_in [16];
	logic [31:0] byte_val [16];
	logic [31:0] next_w;
	logic [3:0]  idx;
	logic [1:0]  pos;

	assign idx    = cmd.fill[5:2];
	assign pos    = cmd.fill[1:0];
	assign next_w = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
	assign wt     = win_q[0];

	always_comb begin
		for (int i = 0; i < 15; i++) begin
			shift_in[i] = win_q[i + 1];
		end
		shift_in[15] = next_w;
	end

	// A byte lands in its lane; the first byte of a word clears the other lanes.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			byte_val[i] = win_q[i];
			for (int j = 0; j < 4; j++) begin
				if (pos == 2'(j)) begin
					byte_val[i][31 - 8 * j -: 8] = cmd.data;
				end else if (pos == 2'd0) begin
					byte_val[i][31 - 8 * j -: 8] = 8'h00;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 16; i++) begin
			if (cmd.step) begin
				win_q[i] <= shift_in[i];
			end else if (cmd.wr_len && (4'(i) == LEN_HI_WORD)) begin
				win_q[i] <= len[63:32];
			end else if (cmd.wr_len && (4'(i) == LEN_LO_WORD)) begin
				win_q[i] <= len[31:0];
			end else if (cmd.zero_all) begin
				win_q[i] <= '0;
			end else if (cmd.wr_byte && (idx == 4'(i))) begin
				win_q[i] <= byte_val[i];
			end else if (cmd.clr_tail && (idx < 4'(i))) begin
				win_q[i] <= '0;
			end
		end
	end

endmodule

`default_nettype wire

[design/sha_core.sv]
// ----------------------------------------------------------------------------
// sha_core: compression round unit and chaining words
// One SHA-256 round per step over the working words a..h, plus the chaining
// words that the block result is added into and the digest is read from.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_core (
	input  logic               clk,
	input  logic               arst_n,
	input  sha_pkg::core_cmd_t cmd,
	input  logic [31:0]        wt,
	output logic [31:0]        word
);
	import sha_pkg::*;

	logic [31:0] chain_q [8];
	logic [31:0] work_q  [8];
	logic [31:0] ch;
	logic [31:0] mj;
	logic [31:0] t1;
	logic [31:0] t2;

	assign ch = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign mj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1 = work_q[7] + big_sigma1(work_q[4]) + ch + ROUND_K[cmd.rnd] + wt;
	assign t2 = big_sigma0(work_q[0]) + mj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= INIT_H;
		end else if (cmd.init) begin
			chain_q <= INIT_H;
		end else if (cmd.update) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + work_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= chain_q;
		end else if (cmd.step) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	assign word = chain_q[cmd.sel];

endmodule

`default_nettype wire
